FILE: rtl/bss_pkg.sv
// Shared types and constants for the bounded substring search block.
package bss_pkg;

    typedef enum logic [1:0] {
        ST_SEARCHING = 2'd0,
        ST_FOUND     = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    localparam logic [1:0] CFG_NEEDLE_LO  = 2'd0;
    localparam logic [1:0] CFG_NEEDLE_HI  = 2'd1;
    localparam logic [1:0] CFG_NEEDLE_LEN = 2'd2;
    localparam logic [1:0] CFG_MAX_SEARCH = 2'd3;

    typedef struct packed {
        logic       shift;
        logic [4:0] len;
    } t_cell_ctl;

endpackage

FILE: rtl/bss_if.sv
// Handshake channel interfaces for the bounded substring search block.
interface bss_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] hay_byte;
    logic       first_byte;

    modport source (output valid, hay_byte, first_byte, input ready);
    modport sink   (input valid, hay_byte, first_byte, output ready);
endinterface

interface bss_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  search_status;
    logic [15:0] match_start;

    modport source (output valid, search_status, match_start, input ready);
    modport sink   (input valid, search_status, match_start, output ready);
endinterface

interface bss_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [63:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/bss_cell.sv
// One window cell: compares the byte at its distance and passes it on.
module bss_cell
    import bss_pkg::*;
#(
    parameter int NEEDLE_MAX = 16,
    parameter int DIST       = 0
) (
    input  logic                        i_clk,
    input  logic [7:0]                  i_byte,
    input  logic [NEEDLE_MAX-1:0][7:0]  i_needle,
    input  t_cell_ctl                   i_ctl,
    output logic [7:0]                  o_byte,
    output logic                        o_match
);

    localparam int IDX_W = (NEEDLE_MAX > 1) ? $clog2(NEEDLE_MAX) : 1;

    logic [7:0] r_byte;
    logic [4:0] w_idx;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_byte <= i_byte;
        end
    end

    always_comb begin
        w_idx   = i_ctl.len - 5'd1 - 5'(DIST);
        o_match = (5'(DIST) >= i_ctl.len) || (i_byte == i_needle[w_idx[IDX_W-1:0]]);
    end

    assign o_byte = r_byte;

endmodule

FILE: rtl/bounded_substring_search.sv
// Top level of the bounded substring search block: control, cell chain, output skid.
//
//  channel  | dir | fields                          | accepted when
//  i_in     | in  | hay_byte[7:0], first_byte      | valid && ready
//  o_out    | out | search_status[1:0], match_start | valid && ready
//  i_cfg    | in  | index[1:0], data[63:0]          | valid && ready (ready always high)
//
// One byte per cycle while the skid entry is free; the byte is compared against the
// needle in the same cycle by a chain of NEEDLE_MAX cells and the result lands in the
// two-entry output (register plus skid), which keeps input flowing while o_out stalls.
// Synchronous active-low reset clears control state and configuration.
// Input ready drops only while the skid entry is occupied.
module bounded_substring_search
    import bss_pkg::*;
#(
    parameter int NEEDLE_MAX = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bss_in_if.sink      i_in,
    bss_out_if.source   o_out,
    bss_cfg_if.sink     i_cfg
);

    logic [63:0] r_needle_lo;
    logic [63:0] r_needle_hi;
    logic [4:0]  r_len;
    logic [15:0] r_max;

    t_status     r_status;
    logic [16:0] r_pos;
    logic [15:0] r_start;

    logic        r_out_valid;
    logic [1:0]  r_out_status;
    logic [15:0] r_out_start;
    logic        r_skid_valid;
    logic [1:0]  r_skid_status;
    logic [15:0] r_skid_start;

    t_status     n_status;
    logic [16:0] n_pos;
    logic [15:0] n_start;

    logic [NEEDLE_MAX-1:0][7:0] w_needle;
    logic [NEEDLE_MAX-1:0][7:0] w_hop;
    logic [NEEDLE_MAX-1:0]      w_match;
    t_cell_ctl                  w_ctl;
    logic                       w_accept;
    logic [4:0]                 w_len;
    t_status                    w_status;
    logic [16:0]                w_pos;
    logic [15:0]                w_start;
    logic [17:0]                w_pos_inc;
    logic [15:0]                w_res_start;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_skid_valid;
    assign w_accept    = i_in.valid && !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_needle_lo <= '0;
            r_needle_hi <= '0;
            r_len       <= '0;
            r_max       <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_NEEDLE_LO:  r_needle_lo <= i_cfg.data;
                CFG_NEEDLE_HI:  r_needle_hi <= i_cfg.data;
                CFG_NEEDLE_LEN: r_len       <= i_cfg.data[4:0];
                CFG_MAX_SEARCH: r_max       <= i_cfg.data[15:0];
                default: ;
            endcase
        end
    end

    for (genvar k = 0; k < NEEDLE_MAX; k++) begin : g_needle
        if (k < 8) begin : g_lo
            assign w_needle[k] = r_needle_lo[k*8 +: 8];
        end else begin : g_hi
            assign w_needle[k] = r_needle_hi[(k-8)*8 +: 8];
        end
    end

    assign w_len = (r_len > 5'(NEEDLE_MAX)) ? 5'(NEEDLE_MAX) : r_len;

    always_comb begin
        w_status    = i_in.first_byte ? ST_SEARCHING : r_status;
        w_pos       = i_in.first_byte ? 17'd0 : r_pos;
        w_start     = i_in.first_byte ? 16'd0 : r_start;
        w_pos_inc   = {1'b0, w_pos} + 18'd1;
        w_res_start = w_pos_inc[15:0] - 16'(w_len);
        n_status    = w_status;
        n_start     = w_start;
        n_pos       = w_pos;
        if (w_status == ST_SEARCHING) begin
            if (r_max == 16'd0 || 16'(w_len) > r_max) begin
                n_status = ST_NOT_FOUND;
            end else if (w_len == 5'd0) begin
                n_status = ST_FOUND;
                n_start  = 16'd0;
            end else if (w_pos < {1'b0, r_max} && w_pos_inc >= 18'(w_len) && (&w_match)) begin
                n_status = ST_FOUND;
                n_start  = w_res_start;
            end else if (w_pos_inc >= {2'b00, r_max}) begin
                n_status = ST_NOT_FOUND;
            end
            if (w_pos != 17'h1FFFF) begin
                n_pos = w_pos + 17'd1;
            end
        end
    end

    assign w_ctl.shift = w_accept && (w_status == ST_SEARCHING);
    assign w_ctl.len   = w_len;
    assign w_hop[0]    = i_in.hay_byte;

    for (genvar d = 0; d < NEEDLE_MAX; d++) begin : g_cell
        if (d < NEEDLE_MAX - 1) begin : g_mid
            bss_cell #(.NEEDLE_MAX(NEEDLE_MAX), .DIST(d)) u_cell (
                .i_clk    (i_clk),
                .i_byte   (w_hop[d]),
                .i_needle (w_needle),
                .i_ctl    (w_ctl),
                .o_byte   (w_hop[d+1]),
                .o_match  (w_match[d])
            );
        end else begin : g_end
            bss_cell #(.NEEDLE_MAX(NEEDLE_MAX), .DIST(d)) u_cell (
                .i_clk    (i_clk),
                .i_byte   (w_hop[d]),
                .i_needle (w_needle),
                .i_ctl    (w_ctl),
                .o_byte   (),
                .o_match  (w_match[d])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status <= ST_SEARCHING;
            r_pos    <= '0;
            r_start  <= '0;
        end else if (w_accept) begin
            r_status <= n_status;
            r_pos    <= n_pos;
            r_start  <= n_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || o_out.ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_accept;
            end
        end else if (w_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || o_out.ready) begin
            if (r_skid_valid) begin
                r_out_status <= r_skid_status;
                r_out_start  <= r_skid_start;
            end else begin
                r_out_status <= n_status;
                r_out_start  <= (n_status == ST_FOUND) ? n_start : 16'd0;
            end
        end else if (w_accept) begin
            r_skid_status <= n_status;
            r_skid_start  <= (n_status == ST_FOUND) ? n_start : 16'd0;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.search_status = r_out_status;
    assign o_out.match_start   = r_out_start;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without output entry");

    a_start_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != ST_FOUND) |-> (r_out_start == 16'd0))
        else $error("match start nonzero without found status");

    a_decision_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_in.first_byte && r_status != ST_SEARCHING)
        |=> (r_status == $past(r_status) && r_start == $past(r_start)))
        else $error("decided status changed without first byte");

    a_no_shift_decided: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_in.first_byte && r_status != ST_SEARCHING) |-> !w_ctl.shift)
        else $error("window shifted after decision");

endmodule
